[rtl/ota_pkg.sv]
// ----------------------------------------------------------------------------
// ota_pkg: shared types and constants of the owner-tagged slot allocator
// Defines the channel words, the action codes and the request token that
// travels along the row of slot cells.
// ----------------------------------------------------------------------------
package ota_pkg;

	// Sizing of the slot table.
	localparam int SLOTS      = 64;
	localparam int OWNER_BITS = 16;
	localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// Fixed widths of the channel fields.
	localparam int ACTION_W   = 2;
	localparam int OWNER_ID_W = 16;
	localparam int SLOT_IDX_W = 6;
	localparam int GRANT_W    = 6;

	// Cell index width wide enough for both the slot number and the request index.
	localparam int CMP_W    = (SLOT_BITS > SLOT_IDX_W) ? SLOT_BITS : SLOT_IDX_W;
	// Number of owner_id bits that survive into the stored tag.
	localparam int OWN_CUT  = (OWNER_BITS < OWNER_ID_W) ? OWNER_BITS : OWNER_ID_W;

	// Request codes.
	typedef enum logic [ACTION_W-1:0] {
		ACT_ALLOC      = 2'd0,
		ACT_FREE_SLOT  = 2'd1,
		ACT_FREE_OWNER = 2'd2
	} action_t;

	// Status codes.
	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef logic [OWNER_BITS-1:0] owner_t;
	typedef logic [CMP_W-1:0]      cell_idx_t;

	// Input word.
	typedef struct packed {
		logic [ACTION_W-1:0]   action;
		logic [OWNER_ID_W-1:0] owner_id;
		logic [SLOT_IDX_W-1:0] slot_index;
	} in_word_t;

	// Output word.
	typedef struct packed {
		logic               status;
		logic [GRANT_W-1:0] granted_slot;
	} out_word_t;

	// Request token handed from cell to cell.
	typedef struct packed {
		logic                  valid;
		logic [ACTION_W-1:0]   action;
		owner_t                owner;
		logic [SLOT_IDX_W-1:0] slot_index;
		logic                  granted;
		logic [GRANT_W-1:0]    grant_slot;
	} tok_t;

	// Cut or extend an owner_id to the stored tag width.
	function automatic owner_t to_owner(input logic [OWNER_ID_W-1:0] id);
		owner_t r;
		r = '0;
		r[OWN_CUT-1:0] = id[OWN_CUT-1:0];
		return r;
	endfunction

endpackage

[rtl/ota_cell.sv]
// ----------------------------------------------------------------------------
// ota_cell: one slot of the allocator
// Holds the busy bit and owner tag of one slot, acts on the request token as
// it passes, and hands the token to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module ota_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  ota_pkg::cell_idx_t cell_index,
	input  ota_pkg::tok_t     tok_in,
	output ota_pkg::tok_t     tok_out
);
	import ota_pkg::*;

	logic      busy_q;
	owner_t    owner_q;
	tok_t      tok_q;
	logic      hit_alloc;
	logic      hit_slot;
	logic      hit_owner;
	cell_idx_t req_index;

	// Decode what the passing request means for this slot.
	always_comb begin
		req_index = CMP_W'(tok_in.slot_index);
		hit_alloc = tok_in.valid && (tok_in.action == ACT_ALLOC) && !tok_in.granted
			&& !busy_q;
		hit_slot  = tok_in.valid && (tok_in.action == ACT_FREE_SLOT)
			&& (req_index == cell_index);
		hit_owner = tok_in.valid && (tok_in.action == ACT_FREE_OWNER) && busy_q
			&& (owner_q == tok_in.owner);
	end

	// Slot state and the token register toward the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			tok_q  <= '0;
		end else begin
			if (hit_alloc) begin
				busy_q <= 1'b1;
			end else if (hit_slot || hit_owner) begin
				busy_q <= 1'b0;
			end
			tok_q.valid      <= tok_in.valid;
			tok_q.action     <= tok_in.action;
			tok_q.owner      <= tok_in.owner;
			tok_q.slot_index <= tok_in.slot_index;
			if (hit_alloc) begin
				tok_q.granted    <= 1'b1;
				tok_q.grant_slot <= cell_index[GRANT_W-1:0];
			end else begin
				tok_q.granted    <= tok_in.granted;
				tok_q.grant_slot <= tok_in.grant_slot;
			end
		end
	end

	// The owner tag carries no reset; it is written on a grant.
	always_ff @(posedge clk) begin
		if (hit_alloc) begin
			owner_q <= tok_in.owner;
		end
	end

	assign tok_out = tok_q;

endmodule

[rtl/owner_tagged_slot_allocator.sv]
// ----------------------------------------------------------------------------
// owner_tagged_slot_allocator: first-free slot allocator with owner tags
// A row of slot cells that a request word walks through one cell per cycle.
// ----------------------------------------------------------------------------
// Each request word enters the first slot cell and moves one cell per clock
// along the row of SLOTS cells; each cell frees or grants its own slot as the
// word passes, so an allocate takes the lowest free slot. The result is
// registered at the output after the word has passed the whole cell row. One
// request is in the row at a time; the next word is taken once the previous
// result has left the row, even while that result still waits at the output.
// A result that leaves the row while an older one is still stalled at the
// output is parked, and the input stays stalled until it moves up. Busy bits
// clear at reset, so the block accepts words right after reset.
module owner_tagged_slot_allocator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ota_pkg::in_word_t in_word,
	output logic              out_valid,
	input  logic              out_stall,
	output ota_pkg::out_word_t out_word
);
	import ota_pkg::*;

	tok_t      chain [SLOTS+1];
	cell_idx_t idx_c [SLOTS];
	logic [SLOTS:0] chain_valid;
	tok_t      head_tok;

	logic      in_flight_q;
	logic      out_valid_q;
	out_word_t out_q;
	logic      pend_valid_q;
	out_word_t pend_q;

	logic      in_accept;
	logic      out_take;
	logic      exit_valid;
	out_word_t exit_word;

	assign in_stall  = in_flight_q;
	assign in_accept = in_valid && !in_flight_q;
	assign out_take  = out_valid_q && !out_stall;

	// Build the request token at the head of the row.
	always_comb begin
		head_tok.valid      = in_accept;
		head_tok.action     = in_word.action;
		head_tok.owner      = to_owner(in_word.owner_id);
		head_tok.slot_index = in_word.slot_index;
		head_tok.granted    = 1'b0;
		head_tok.grant_slot = '0;
	end

	assign chain[0] = head_tok;

	// The row of slot cells.
	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		assign idx_c[g] = CMP_W'(g);
		ota_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_index (idx_c[g]),
			.tok_in     (chain[g]),
			.tok_out    (chain[g+1])
		);
	end

	for (genvar v = 0; v <= SLOTS; v++) begin : g_vld
		assign chain_valid[v] = chain[v].valid;
	end

	// Result of the token leaving the last cell.
	always_comb begin
		exit_valid = chain[SLOTS].valid;
		exit_word.status = ((chain[SLOTS].action == ACT_ALLOC) && !chain[SLOTS].granted)
			? STATUS_FULL : STATUS_DONE;
		exit_word.granted_slot = chain[SLOTS].grant_slot;
	end

	// Control: in-flight flag, output register and one pending result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_flight_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				in_flight_q <= 1'b1;
			end else if (exit_valid && (!out_valid_q || out_take)) begin
				in_flight_q <= 1'b0;
			end else if (pend_valid_q && out_take) begin
				in_flight_q <= 1'b0;
			end

			if (exit_valid && !(!out_valid_q || out_take)) begin
				pend_valid_q <= 1'b1;
			end else if (out_take) begin
				pend_valid_q <= 1'b0;
			end

			if (exit_valid || pend_valid_q) begin
				if (!out_valid_q || out_take) begin
					out_valid_q <= 1'b1;
				end
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output and pending payload.
	always_ff @(posedge clk) begin
		if (exit_valid) begin
			if (!out_valid_q || out_take) begin
				out_q <= exit_word;
			end else begin
				pend_q <= exit_word;
			end
		end else if (pend_valid_q && out_take) begin
			out_q <= pend_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

`ifndef SYNTH
	// At most one request token is ever in the row.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(chain_valid) <= 1)
		else $error("more than one request token in the cell row");

	// A token leaving the row belongs to an accepted request.
	a_exit_owned: assert property (@(posedge clk) disable iff (!arst_n)
		exit_valid |-> in_flight_q)
		else $error("token left the row with no request in flight");

	// A pending result only exists behind a full output register.
	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("pending result without an output result");

	// No token can arrive while a pending result still waits.
	a_no_exit_on_pend: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> !exit_valid)
		else $error("token left the row while a result was pending");
`endif

endmodule
